/* src/crr_pkg.sv */
// Catmull-Rom resampler shared types, constants and the control store.
package crr_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 24;
    localparam int TAPS        = 4;
    localparam int RATIO_BITS  = 31;
    localparam int PHASE_BITS  = 32;
    localparam int MU_BITS     = FRAC_BITS + 1;
    localparam int ACC_BITS    = 32;
    localparam int PROD_BITS   = ACC_BITS - 1 + MU_BITS;
    localparam int PC_BITS     = 5;

    localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;

    localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(ONE_L);
    // passthrough window, open interval 0.9999 .. 1.00001
    localparam logic [RATIO_BITS-1:0] PASS_LO = RATIO_BITS'((ONE_L * 9999) / 10000 + 1);
    localparam logic [RATIO_BITS-1:0] PASS_HI = RATIO_BITS'((ONE_L * 100001 - 1) / 100000);

    localparam logic [PHASE_BITS-1:0] ONE_PH    = PHASE_BITS'(ONE_L);
    localparam logic [MU_BITS-1:0]    ONE_MU    = MU_BITS'(ONE_L);
    localparam logic [PROD_BITS-1:0]  HALF_PROD = PROD_BITS'(ONE_L >> 1);

    localparam logic signed [ACC_BITS-1:0] SAT_HI =
        ACC_BITS'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_BITS-1:0] SAT_LO =
        ACC_BITS'(-(longint'(1) <<< (SAMPLE_BITS - 1)));

    typedef enum logic [1:0] {
        H_NONE = 2'd0,
        H_IN   = 2'd1,
        H_OUT  = 2'd2,
        H_PEND = 2'd3
    } t_hold;

    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_ACCEPT    = 4'd1,
        OP_PUSH_UP   = 4'd2,
        OP_PUSH_DN   = 4'd3,
        OP_SUB_RATIO = 4'd4,
        OP_MU_DN     = 4'd5,
        OP_MU_UP     = 4'd6,
        OP_LOAD      = 4'd7,
        OP_MUL       = 4'd8,
        OP_ADD_A1    = 4'd9,
        OP_ADD_A2    = 4'd10,
        OP_ADD_Y1    = 4'd11,
        OP_EMIT      = 4'd12,
        OP_FLUSH     = 4'd13,
        OP_PASS      = 4'd14
    } t_op;

    typedef enum logic [2:0] {
        C_NONE     = 3'd0,
        C_ALWAYS   = 3'd1,
        C_PASS     = 3'd2,
        C_UP       = 3'd3,
        C_NMAX     = 3'd4,
        C_GE_RATIO = 3'd5,
        C_LT_ONE   = 3'd6,
        C_TAKEN    = 3'd7
    } t_cond;

    typedef struct packed {
        t_hold              hold;
        t_op                op;
        t_cond              cond;
        logic [PC_BITS-1:0] target;
    } t_uword;

    typedef struct packed {
        logic pass;
        logic up;
        logic nmax;
        logic ge_ratio;
        logic lt_one;
        logic taken;
        logic out_free;
        logic pend_ok;
    } t_stat;

    localparam logic [PC_BITS-1:0] S_IDLE     = PC_BITS'(0);
    localparam logic [PC_BITS-1:0] S_DISP     = PC_BITS'(1);
    localparam logic [PC_BITS-1:0] S_DISP2    = PC_BITS'(2);
    localparam logic [PC_BITS-1:0] S_D_LOOP   = PC_BITS'(3);
    localparam logic [PC_BITS-1:0] S_D_CHK    = PC_BITS'(4);
    localparam logic [PC_BITS-1:0] S_D_TST    = PC_BITS'(5);
    localparam logic [PC_BITS-1:0] S_D_TAKE   = PC_BITS'(6);
    localparam logic [PC_BITS-1:0] S_D_OUT    = PC_BITS'(7);
    localparam logic [PC_BITS-1:0] S_D_MU     = PC_BITS'(8);
    localparam logic [PC_BITS-1:0] S_D_END    = PC_BITS'(9);
    localparam logic [PC_BITS-1:0] S_D_PUSH   = PC_BITS'(10);
    localparam logic [PC_BITS-1:0] S_U_LOOP   = PC_BITS'(11);
    localparam logic [PC_BITS-1:0] S_U_CHK    = PC_BITS'(12);
    localparam logic [PC_BITS-1:0] S_U_TST    = PC_BITS'(13);
    localparam logic [PC_BITS-1:0] S_U_TAKE   = PC_BITS'(14);
    localparam logic [PC_BITS-1:0] S_U_OUT    = PC_BITS'(15);
    localparam logic [PC_BITS-1:0] S_I_LOAD   = PC_BITS'(16);
    localparam logic [PC_BITS-1:0] S_I_MUL0   = PC_BITS'(17);
    localparam logic [PC_BITS-1:0] S_I_A1     = PC_BITS'(18);
    localparam logic [PC_BITS-1:0] S_I_MUL1   = PC_BITS'(19);
    localparam logic [PC_BITS-1:0] S_I_A2     = PC_BITS'(20);
    localparam logic [PC_BITS-1:0] S_I_MUL2   = PC_BITS'(21);
    localparam logic [PC_BITS-1:0] S_I_Y1     = PC_BITS'(22);
    localparam logic [PC_BITS-1:0] S_I_EMIT   = PC_BITS'(23);
    localparam logic [PC_BITS-1:0] S_I_RET    = PC_BITS'(24);
    localparam logic [PC_BITS-1:0] S_U_END    = PC_BITS'(25);
    localparam logic [PC_BITS-1:0] S_U_PUSH   = PC_BITS'(26);
    localparam logic [PC_BITS-1:0] S_FINISH   = PC_BITS'(27);
    localparam logic [PC_BITS-1:0] S_PASS     = PC_BITS'(28);
    localparam logic [PC_BITS-1:0] S_LAST     = S_PASS;

    function automatic t_uword ucode(input logic [PC_BITS-1:0] pc);
        t_uword uw;
        unique case (pc)
            S_IDLE:   uw = '{H_IN,   OP_ACCEPT,    C_NONE,     S_IDLE};
            S_DISP:   uw = '{H_NONE, OP_NOP,       C_PASS,     S_PASS};
            S_DISP2:  uw = '{H_NONE, OP_NOP,       C_UP,       S_U_LOOP};
            S_D_LOOP: uw = '{H_NONE, OP_NOP,       C_NMAX,     S_D_END};
            S_D_CHK:  uw = '{H_NONE, OP_NOP,       C_GE_RATIO, S_D_OUT};
            S_D_TST:  uw = '{H_NONE, OP_NOP,       C_TAKEN,    S_FINISH};
            S_D_TAKE: uw = '{H_NONE, OP_PUSH_DN,   C_ALWAYS,   S_D_CHK};
            S_D_OUT:  uw = '{H_NONE, OP_SUB_RATIO, C_NONE,     S_IDLE};
            S_D_MU:   uw = '{H_NONE, OP_MU_DN,     C_ALWAYS,   S_I_LOAD};
            S_D_END:  uw = '{H_NONE, OP_NOP,       C_TAKEN,    S_FINISH};
            S_D_PUSH: uw = '{H_NONE, OP_PUSH_DN,   C_ALWAYS,   S_FINISH};
            S_U_LOOP: uw = '{H_NONE, OP_NOP,       C_NMAX,     S_U_END};
            S_U_CHK:  uw = '{H_NONE, OP_NOP,       C_LT_ONE,   S_U_OUT};
            S_U_TST:  uw = '{H_NONE, OP_NOP,       C_TAKEN,    S_FINISH};
            S_U_TAKE: uw = '{H_NONE, OP_PUSH_UP,   C_NONE,     S_IDLE};
            S_U_OUT:  uw = '{H_NONE, OP_MU_UP,     C_NONE,     S_IDLE};
            S_I_LOAD: uw = '{H_NONE, OP_LOAD,      C_NONE,     S_IDLE};
            S_I_MUL0: uw = '{H_NONE, OP_MUL,       C_NONE,     S_IDLE};
            S_I_A1:   uw = '{H_NONE, OP_ADD_A1,    C_NONE,     S_IDLE};
            S_I_MUL1: uw = '{H_NONE, OP_MUL,       C_NONE,     S_IDLE};
            S_I_A2:   uw = '{H_NONE, OP_ADD_A2,    C_NONE,     S_IDLE};
            S_I_MUL2: uw = '{H_NONE, OP_MUL,       C_NONE,     S_IDLE};
            S_I_Y1:   uw = '{H_NONE, OP_ADD_Y1,    C_NONE,     S_IDLE};
            S_I_EMIT: uw = '{H_PEND, OP_EMIT,      C_UP,       S_U_LOOP};
            S_I_RET:  uw = '{H_NONE, OP_NOP,       C_ALWAYS,   S_D_LOOP};
            S_U_END:  uw = '{H_NONE, OP_NOP,       C_TAKEN,    S_FINISH};
            S_U_PUSH: uw = '{H_NONE, OP_PUSH_UP,   C_NONE,     S_IDLE};
            S_FINISH: uw = '{H_PEND, OP_FLUSH,     C_ALWAYS,   S_IDLE};
            S_PASS:   uw = '{H_OUT,  OP_PASS,      C_ALWAYS,   S_IDLE};
            default:  uw = '{H_NONE, OP_NOP,       C_ALWAYS,   S_IDLE};
        endcase
        return uw;
    endfunction

endpackage

/* src/crr_useq.sv */
// Catmull-Rom resampler microsequencer: step counter, control store, branch logic.
module crr_useq import crr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  t_stat  i_stat,
    output t_uword o_uw,
    output logic   o_fire
);

    logic [PC_BITS-1:0] r_pc;
    logic [PC_BITS-1:0] n_pc;
    logic               go;
    logic               cond_true;

    assign o_uw   = ucode(r_pc);
    assign o_fire = go;

    always_comb begin
        unique case (o_uw.hold)
            H_NONE: go = 1'b1;
            H_IN:   go = i_in_valid;
            H_OUT:  go = i_stat.out_free;
            H_PEND: go = i_stat.pend_ok;
        endcase
    end

    always_comb begin
        unique case (o_uw.cond)
            C_NONE:     cond_true = 1'b0;
            C_ALWAYS:   cond_true = 1'b1;
            C_PASS:     cond_true = i_stat.pass;
            C_UP:       cond_true = i_stat.up;
            C_NMAX:     cond_true = i_stat.nmax;
            C_GE_RATIO: cond_true = i_stat.ge_ratio;
            C_LT_ONE:   cond_true = i_stat.lt_one;
            C_TAKEN:    cond_true = i_stat.taken;
        endcase
    end

    always_comb begin
        n_pc = r_pc;
        if (go) begin
            n_pc = cond_true ? o_uw.target : r_pc + PC_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    a_pc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= S_LAST)
        else $error("step counter left the program");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_fire && o_uw.op == OP_ACCEPT) |=> (r_pc == S_DISP))
        else $error("accepted request not dispatched");

    a_hold_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_fire |=> $stable(r_pc))
        else $error("step counter moved while held");

endmodule

/* src/crr_dp.sv */
// Catmull-Rom resampler datapath: history, phase, Horner unit, pending and output registers.
module crr_dp import crr_pkg::*; #(
    parameter int MAX_UPSAMPLE = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [RATIO_BITS-1:0]         i_ratio,
    input  t_uword                        i_uw,
    input  logic                          i_fire,
    input  logic                          i_out_stall,
    output t_stat                         o_stat,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                          o_last_of_run,
    output logic                          o_out_valid
);

    localparam int N_W = $clog2(MAX_UPSAMPLE + 1);
    localparam logic [N_W-1:0] N_MAX = N_W'(MAX_UPSAMPLE);

    logic signed [SAMPLE_BITS-1:0] r_hist [TAPS];
    logic signed [SAMPLE_BITS-1:0] n_hist [TAPS];
    logic signed [SAMPLE_BITS-1:0] r_sample, n_sample;
    logic [PHASE_BITS-1:0]         r_phase, n_phase;
    logic [MU_BITS-1:0]            r_mu, n_mu;
    logic signed [ACC_BITS-1:0]    r_t, n_t;
    logic [PROD_BITS-1:0]          r_prod, n_prod;
    logic                          r_neg, n_neg;
    logic [N_W-1:0]                r_n, n_n;
    logic                          r_taken, n_taken;
    logic [SAMPLE_BITS-1:0]        r_pend, n_pend;
    logic                          r_pend_v, n_pend_v;
    logic [SAMPLE_BITS-1:0]        r_out, n_out;
    logic                          r_out_last, n_out_last;
    logic                          r_out_valid, n_out_valid;

    logic signed [ACC_BITS-1:0] y0, y1, y2, y3, d12;
    logic signed [ACC_BITS-1:0] a0, a1, a2, y1x2;
    logic [ACC_BITS-1:0]        t_u, abs_t;
    logic [PROD_BITS-1:0]       prod_w, rnd;
    logic [ACC_BITS-1:0]        pmag;
    logic signed [ACC_BITS-1:0] pterm;
    logic [ACC_BITS-1:0]        rmag;
    logic signed [ACC_BITS-1:0] rs;
    logic [SAMPLE_BITS-1:0]     res;
    logic [PHASE_BITS-1:0]      ratio_ext;
    logic                       ge_one;
    logic [MU_BITS-1:0]         mu_dn, mu_up;
    logic                       out_free;
    logic                       do_push;

    // y0 oldest .. y3 newest
    assign y0   = ACC_BITS'(r_hist[3]);
    assign y1   = ACC_BITS'(r_hist[2]);
    assign y2   = ACC_BITS'(r_hist[1]);
    assign y3   = ACC_BITS'(r_hist[0]);
    assign d12  = y1 - y2;
    assign a0   = y3 - y0 + (d12 <<< 1) + d12;
    assign a1   = (y0 <<< 1) - (y1 <<< 2) - y1 + (y2 <<< 2) - y3;
    assign a2   = y2 - y0;
    assign y1x2 = y1 <<< 1;

    assign t_u    = r_t;
    assign abs_t  = t_u[ACC_BITS-1] ? (~t_u + ACC_BITS'(1)) : t_u;
    assign prod_w = PROD_BITS'(abs_t[ACC_BITS-2:0]) * PROD_BITS'(r_mu);

    // rounded magnitude, ties away from zero
    assign rnd   = r_prod + HALF_PROD;
    assign pmag  = ACC_BITS'(rnd >> FRAC_BITS);
    assign pterm = r_neg ? -$signed(pmag) : $signed(pmag);

    assign rmag = (abs_t + ACC_BITS'(1)) >> 1;
    assign rs   = t_u[ACC_BITS-1] ? -$signed(rmag) : $signed(rmag);

    always_comb begin
        priority if (rs > SAT_HI) begin
            res = SAT_HI[SAMPLE_BITS-1:0];
        end else if (rs < SAT_LO) begin
            res = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            res = rs[SAMPLE_BITS-1:0];
        end
    end

    assign ratio_ext = PHASE_BITS'(i_ratio);
    assign ge_one    = r_phase >= ONE_PH;
    assign mu_dn     = ge_one ? '0 : MU_BITS'(ONE_PH - r_phase);
    assign mu_up     = ge_one ? ONE_MU : r_phase[MU_BITS-1:0];
    assign out_free  = !r_out_valid || !i_out_stall;

    assign o_stat.pass     = (i_ratio >= PASS_LO) && (i_ratio <= PASS_HI);
    assign o_stat.up       = i_ratio < RATIO_ONE;
    assign o_stat.nmax     = r_n == N_MAX;
    assign o_stat.ge_ratio = r_phase >= ratio_ext;
    assign o_stat.lt_one   = !ge_one;
    assign o_stat.taken    = r_taken;
    assign o_stat.out_free = out_free;
    assign o_stat.pend_ok  = !r_pend_v || out_free;

    always_comb begin
        n_hist      = r_hist;
        n_sample    = r_sample;
        n_phase     = r_phase;
        n_mu        = r_mu;
        n_t         = r_t;
        n_prod      = r_prod;
        n_neg       = r_neg;
        n_n         = r_n;
        n_taken     = r_taken;
        n_pend      = r_pend;
        n_pend_v    = r_pend_v;
        n_out       = r_out;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid;
        do_push     = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_fire) begin
            unique case (i_uw.op)
                OP_NOP: begin
                end
                OP_ACCEPT: begin
                    n_sample = i_sample;
                    n_taken  = 1'b0;
                    n_n      = '0;
                end
                OP_PUSH_UP: begin
                    do_push = 1'b1;
                    n_taken = 1'b1;
                    if (ge_one) begin
                        n_phase = r_phase - ONE_PH;
                    end
                end
                OP_PUSH_DN: begin
                    do_push = 1'b1;
                    n_taken = 1'b1;
                    n_phase = r_phase + ONE_PH;
                end
                OP_SUB_RATIO: begin
                    n_phase = r_phase - ratio_ext;
                end
                OP_MU_DN: begin
                    n_mu = mu_dn;
                end
                OP_MU_UP: begin
                    n_mu    = mu_up;
                    n_phase = r_phase + ratio_ext;
                end
                OP_LOAD: begin
                    n_t = a0;
                end
                OP_MUL: begin
                    n_prod = prod_w;
                    n_neg  = t_u[ACC_BITS-1];
                end
                OP_ADD_A1: begin
                    n_t = a1 + pterm;
                end
                OP_ADD_A2: begin
                    n_t = a2 + pterm;
                end
                OP_ADD_Y1: begin
                    n_t = y1x2 + pterm;
                end
                OP_EMIT: begin
                    if (r_pend_v) begin
                        n_out       = r_pend;
                        n_out_last  = 1'b0;
                        n_out_valid = 1'b1;
                    end
                    n_pend   = res;
                    n_pend_v = 1'b1;
                    n_n      = r_n + N_W'(1);
                end
                OP_FLUSH: begin
                    if (r_pend_v) begin
                        n_out       = r_pend;
                        n_out_last  = 1'b1;
                        n_out_valid = 1'b1;
                    end
                    n_pend_v = 1'b0;
                end
                OP_PASS: begin
                    do_push     = 1'b1;
                    n_out       = r_sample;
                    n_out_last  = 1'b1;
                    n_out_valid = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (do_push) begin
            for (int i = TAPS - 1; i > 0; i--) begin
                n_hist[i] = r_hist[i-1];
            end
            n_hist[0] = r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_hist[i] <= '0;
            end
            r_phase     <= ONE_PH;
            r_n         <= '0;
            r_taken     <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_hist      <= n_hist;
            r_phase     <= n_phase;
            r_n         <= n_n;
            r_taken     <= n_taken;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_mu       <= n_mu;
        r_t        <= n_t;
        r_prod     <= n_prod;
        r_neg      <= n_neg;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_sample_out  = r_out;
    assign o_last_of_run = r_out_last;
    assign o_out_valid   = r_out_valid;

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= N_MAX)
        else $error("result count beyond limit");

    a_mu_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_uw.op == OP_MUL)) |-> (r_mu <= ONE_MU))
        else $error("interpolation position above one");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_uw.op == OP_EMIT && r_pend_v) |-> out_free)
        else $error("pending result overwrites a held output");

endmodule

/* src/catmull_rom_resampler.sv */
// Catmull-Rom cubic sample-rate converter top level: config register and sequencer/datapath.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_stall    i_sample
//   out      source     o_out_valid / i_out_stall  o_sample_out, o_last_of_run
//   cfg      sink       i_cfg_valid / o_cfg_ready  i_cfg_ratio
//
// A request is taken only at the program's idle step; passthrough runs through dispatch
// to the passthrough step. Each interpolated result runs the load, multiply, add and emit
// steps: three multiply/accumulate pairs share one multiplier. An item also passes through
// dispatch, sample push and finish steps.
// Synchronous reset clears history to zero and sets phase and ratio to 1.0.
// Output stall holds the program at its emit, finish or passthrough step; one result may
// wait in the output register while the next request is taken.
module catmull_rom_resampler import crr_pkg::*; #(
    parameter int MAX_UPSAMPLE = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                          o_last_of_run,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [RATIO_BITS-1:0]         i_cfg_ratio
);

    logic [RATIO_BITS-1:0] r_ratio;
    logic [RATIO_BITS-1:0] n_ratio;
    t_uword                uw;
    t_stat                 stat;
    logic                  fire;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (uw.hold != H_IN);

    always_comb begin
        n_ratio = r_ratio;
        if (i_cfg_valid && o_cfg_ready) begin
            n_ratio = i_cfg_ratio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= RATIO_ONE;
        end else begin
            r_ratio <= n_ratio;
        end
    end

    crr_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_uw       (uw),
        .o_fire     (fire)
    );

    crr_dp #(
        .MAX_UPSAMPLE (MAX_UPSAMPLE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sample      (i_sample),
        .i_ratio       (r_ratio),
        .i_uw          (uw),
        .i_fire        (fire),
        .i_out_stall   (i_out_stall),
        .o_stat        (stat),
        .o_sample_out  (o_sample_out),
        .o_last_of_run (o_last_of_run),
        .o_out_valid   (o_out_valid)
    );

endmodule
